@@ design/aarm_pkg.sv @@
// Package: payload types, constants and tables for the axis-angle to rotation matrix block.
package aarm_pkg;

	localparam int FRAC_BITS     = 14;
	localparam int SINCOS_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_STAGES = (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;

	// Half-angle phase in 1/512 degree per half turn
	localparam int HALF_TURN_UNITS = 184320;
	// Offset that makes every input angle positive (a whole number of half turns)
	localparam int ANGLE_OFFSET    = 46 * HALF_TURN_UNITS;
	// floor(2^40 / 184320), quotient estimate low by at most one
	localparam int RECIP_TURN      = 5965232;
	// floor(2^24 / 45), quotient estimate low by at most one
	localparam int RECIP_45        = 372827;
	localparam int DIV_45          = 45;

	localparam int Q30             = 30;
	localparam longint CORDIC_GAIN = 64'd652032874;

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [23:0] angle_deg;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} mat_t;

	// atan(2^-i) in 32-bit binary angle units
	function automatic logic signed [31:0] atan_lut(input int i);
		logic signed [31:0] v;
		case (i)
			0:  v = 32'sd536870912;
			1:  v = 32'sd316933406;
			2:  v = 32'sd167458907;
			3:  v = 32'sd85004756;
			4:  v = 32'sd42667331;
			5:  v = 32'sd21354465;
			6:  v = 32'sd10679838;
			7:  v = 32'sd5340245;
			8:  v = 32'sd2670163;
			9:  v = 32'sd1335087;
			10: v = 32'sd667544;
			11: v = 32'sd333772;
			12: v = 32'sd166886;
			13: v = 32'sd83443;
			14: v = 32'sd41722;
			15: v = 32'sd20861;
			16: v = 32'sd10430;
			17: v = 32'sd5215;
			18: v = 32'sd2608;
			19: v = 32'sd1304;
			20: v = 32'sd652;
			21: v = 32'sd326;
			22: v = 32'sd163;
			23: v = 32'sd81;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// floor(b * 2^20 / 45) for a remainder b below 45
	function automatic logic [19:0] frac45_lut(input logic [5:0] b);
		logic [19:0] v;
		case (b)
			6'd0:  v = 20'd0;       6'd1:  v = 20'd23301;   6'd2:  v = 20'd46603;
			6'd3:  v = 20'd69905;   6'd4:  v = 20'd93206;   6'd5:  v = 20'd116508;
			6'd6:  v = 20'd139810;  6'd7:  v = 20'd163111;  6'd8:  v = 20'd186413;
			6'd9:  v = 20'd209715;  6'd10: v = 20'd233016;  6'd11: v = 20'd256318;
			6'd12: v = 20'd279620;  6'd13: v = 20'd302921;  6'd14: v = 20'd326223;
			6'd15: v = 20'd349525;  6'd16: v = 20'd372827;  6'd17: v = 20'd396128;
			6'd18: v = 20'd419430;  6'd19: v = 20'd442732;  6'd20: v = 20'd466033;
			6'd21: v = 20'd489335;  6'd22: v = 20'd512637;  6'd23: v = 20'd535938;
			6'd24: v = 20'd559240;  6'd25: v = 20'd582542;  6'd26: v = 20'd605843;
			6'd27: v = 20'd629145;  6'd28: v = 20'd652447;  6'd29: v = 20'd675748;
			6'd30: v = 20'd699050;  6'd31: v = 20'd722352;  6'd32: v = 20'd745654;
			6'd33: v = 20'd768955;  6'd34: v = 20'd792257;  6'd35: v = 20'd815559;
			6'd36: v = 20'd838860;  6'd37: v = 20'd862162;  6'd38: v = 20'd885464;
			6'd39: v = 20'd908765;  6'd40: v = 20'd932067;  6'd41: v = 20'd955369;
			6'd42: v = 20'd978670;  6'd43: v = 20'd1001972; 6'd44: v = 20'd1025274;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

	// Round Q30 to FRAC_BITS half up and saturate to 16 bits
	function automatic logic signed [15:0] to_out(input logic signed [39:0] e);
		logic signed [39:0] r;
		r = (e + (40'sd1 <<< (Q30 - FRAC_BITS - 1))) >>> (Q30 - FRAC_BITS);
		if (r > 40'sd32767) return 16'sh7fff;
		if (r < -40'sd32768) return 16'sh8000;
		return r[15:0];
	endfunction

	// Rounded Q30 product, doubled
	function automatic logic signed [37:0] mulq2(input logic signed [33:0] a,
		input logic signed [33:0] b);
		logic signed [67:0] p;
		logic signed [67:0] r;
		p = 68'(a) * 68'(b);
		r = (p + (68'sd1 <<< (Q30 - 1))) >>> Q30;
		return 38'(r <<< 1);
	endfunction

endpackage

@@ design/axis_angle_to_rotation_matrix.sv @@
// Top level: pipelined axis-angle to 3x3 rotation matrix converter.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------
//   cmd     | cmd_valid, cmd_ready | axis_x/y/z Q1.14, angle_deg
//   mat     | mat_valid, mat_ready | m00..m22 Q1.14 saturated
//
// One item per cycle while the output is not stalled; the CORDIC pipeline has
// one stage per iteration (16 CORDIC stages by default).
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the stage valid bits.
module axis_angle_to_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  aarm_pkg::cmd_t     cmd,
	output logic               mat_valid,
	input  logic               mat_ready,
	output aarm_pkg::mat_t     mat
);

	localparam int N = aarm_pkg::CORDIC_STAGES;

	logic en;
	assign en        = !mat_valid || mat_ready;
	assign cmd_ready = en;

	// Stage 1: offset angle, quotient estimate by reciprocal
	logic        v_s1;
	logic [24:0] u_s1;
	logic [6:0]  qe_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic [24:0] u_c;
	logic [47:0] pr1_c;
	assign u_c   = 25'(cmd.angle_deg + 24'sd0) + 25'(aarm_pkg::ANGLE_OFFSET)
		+ (cmd.angle_deg[23] ? 25'h1000000 : 25'd0) - 25'h1000000 * 25'(cmd.angle_deg[23]);
	assign pr1_c = 48'(u_c) * 48'(aarm_pkg::RECIP_TURN);

	// Stage 2: remainder modulo a half turn
	logic        v_s2;
	logic [17:0] p_s2;
	logic signed [15:0] ax_s2, ay_s2, az_s2;
	logic [24:0] r2_c;
	assign r2_c = u_s1 - 25'(qe_s1) * 25'(aarm_pkg::HALF_TURN_UNITS);

	// Stage 3: quotient estimate by 45
	logic        v_s3;
	logic [17:0] p_s3;
	logic [11:0] ae_s3;
	logic signed [15:0] ax_s3, ay_s3, az_s3;
	logic [36:0] pr3_c;
	assign pr3_c = 37'(p_s2) * 37'(aarm_pkg::RECIP_45);

	// Stage 4: binary angle, quadrant and residual
	logic        v_s4;
	logic [1:0]  q_s4;
	logic signed [31:0] z_s4;
	logic signed [15:0] ax_s4, ay_s4, az_s4;
	logic [17:0] b_c;
	logic [11:0] a_c;
	logic [5:0]  bb_c;
	logic [31:0] theta_c, thq_c;
	always_comb begin
		b_c = p_s3 - 18'(ae_s3) * 18'(aarm_pkg::DIV_45);
		a_c = ae_s3;
		if (b_c >= 18'(aarm_pkg::DIV_45)) begin
			b_c = b_c - 18'(aarm_pkg::DIV_45);
			a_c = a_c + 12'd1;
		end
		bb_c    = b_c[5:0];
		theta_c = {a_c, 20'd0} + 32'(aarm_pkg::frac45_lut(bb_c));
		thq_c   = theta_c + 32'h2000_0000;
	end

	// CORDIC pipeline: entry 0 is the stage 4 output, entry k+1 after iteration k
	logic               v_s5  [0:N];
	logic [1:0]         q_s5  [0:N];
	logic signed [33:0] cx_s5 [0:N];
	logic signed [33:0] cy_s5 [0:N];
	logic signed [31:0] cz_s5 [0:N];
	logic signed [15:0] ax_s5 [0:N];
	logic signed [15:0] ay_s5 [0:N];
	logic signed [15:0] az_s5 [0:N];

	assign v_s5[0]  = v_s4;
	assign q_s5[0]  = q_s4;
	assign cx_s5[0] = 34'(aarm_pkg::CORDIC_GAIN);
	assign cy_s5[0] = 34'sd0;
	assign cz_s5[0] = z_s4;
	assign ax_s5[0] = ax_s4;
	assign ay_s5[0] = ay_s4;
	assign az_s5[0] = az_s4;

	for (genvar k = 0; k < N; k++) begin : g_cordic
		logic signed [33:0] xs, ys;
		assign xs = cx_s5[k] >>> k;
		assign ys = cy_s5[k] >>> k;
		// Advance one rotation toward zero residual
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[k+1] <= 1'b0;
			end else if (en) begin
				v_s5[k+1] <= v_s5[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s5[k+1]  <= q_s5[k];
				ax_s5[k+1] <= ax_s5[k];
				ay_s5[k+1] <= ay_s5[k];
				az_s5[k+1] <= az_s5[k];
				if (!cz_s5[k][31]) begin
					cx_s5[k+1] <= cx_s5[k] - ys;
					cy_s5[k+1] <= cy_s5[k] + xs;
					cz_s5[k+1] <= cz_s5[k] - aarm_pkg::atan_lut(k);
				end else begin
					cx_s5[k+1] <= cx_s5[k] + ys;
					cy_s5[k+1] <= cy_s5[k] - xs;
					cz_s5[k+1] <= cz_s5[k] + aarm_pkg::atan_lut(k);
				end
			end
		end
	end

	// Stage 6: quadrant fold, quaternion terms
	logic               v_s6;
	logic signed [33:0] qx_s6, qy_s6, qz_s6, qw_s6;
	logic signed [33:0] cs_c, sn_c;
	logic signed [48:0] px_c, py_c, pz_c;
	always_comb begin
		case (q_s5[N])
			2'd0: begin cs_c = cx_s5[N];  sn_c = cy_s5[N];  end
			2'd1: begin cs_c = -cy_s5[N]; sn_c = cx_s5[N];  end
			2'd2: begin cs_c = -cx_s5[N]; sn_c = -cy_s5[N]; end
			default: begin cs_c = cy_s5[N]; sn_c = -cx_s5[N]; end
		endcase
		px_c = 49'(ax_s5[N]) * 49'(sn_c);
		py_c = 49'(ay_s5[N]) * 49'(sn_c);
		pz_c = 49'(az_s5[N]) * 49'(sn_c);
	end

	localparam logic signed [48:0] QRND = 49'sd1 <<< (aarm_pkg::FRAC_BITS - 1);

	// Stage 7: doubled pairwise products
	logic               v_s7;
	logic signed [37:0] xx_s7, yy_s7, zz_s7, xy_s7, xz_s7, yz_s7, wx_s7, wy_s7, wz_s7;

	// Stage 8: matrix entries in Q30
	logic               v_s8;
	logic signed [39:0] e_s8 [0:8];
	logic signed [39:0] one_c;
	assign one_c = 40'sd1 <<< aarm_pkg::Q30;

	// Hold valid bits of the stages outside the CORDIC pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			mat_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= cmd_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s6      <= v_s5[N];
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			mat_valid <= v_s8;
		end
	end

	// Advance the payload of every stage outside the CORDIC pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u_c;
			qe_s1 <= pr1_c[46:40];
			ax_s1 <= cmd.axis_x;
			ay_s1 <= cmd.axis_y;
			az_s1 <= cmd.axis_z;

			p_s2  <= (r2_c >= 25'(aarm_pkg::HALF_TURN_UNITS))
				? 18'(r2_c - 25'(aarm_pkg::HALF_TURN_UNITS)) : r2_c[17:0];
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;

			p_s3  <= p_s2;
			ae_s3 <= pr3_c[35:24];
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;

			q_s4  <= thq_c[31:30];
			z_s4  <= $signed(theta_c - {thq_c[31:30], 30'd0});
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			az_s4 <= az_s3;

			qx_s6 <= 34'((px_c + QRND) >>> aarm_pkg::FRAC_BITS);
			qy_s6 <= 34'((py_c + QRND) >>> aarm_pkg::FRAC_BITS);
			qz_s6 <= 34'((pz_c + QRND) >>> aarm_pkg::FRAC_BITS);
			qw_s6 <= cs_c;

			xx_s7 <= aarm_pkg::mulq2(qx_s6, qx_s6);
			yy_s7 <= aarm_pkg::mulq2(qy_s6, qy_s6);
			zz_s7 <= aarm_pkg::mulq2(qz_s6, qz_s6);
			xy_s7 <= aarm_pkg::mulq2(qx_s6, qy_s6);
			xz_s7 <= aarm_pkg::mulq2(qx_s6, qz_s6);
			yz_s7 <= aarm_pkg::mulq2(qy_s6, qz_s6);
			wx_s7 <= aarm_pkg::mulq2(qw_s6, qx_s6);
			wy_s7 <= aarm_pkg::mulq2(qw_s6, qy_s6);
			wz_s7 <= aarm_pkg::mulq2(qw_s6, qz_s6);

			e_s8[0] <= one_c - (40'(yy_s7) + 40'(zz_s7));
			e_s8[1] <= 40'(xy_s7) - 40'(wz_s7);
			e_s8[2] <= 40'(xz_s7) + 40'(wy_s7);
			e_s8[3] <= 40'(xy_s7) + 40'(wz_s7);
			e_s8[4] <= one_c - (40'(xx_s7) + 40'(zz_s7));
			e_s8[5] <= 40'(yz_s7) - 40'(wx_s7);
			e_s8[6] <= 40'(xz_s7) - 40'(wy_s7);
			e_s8[7] <= 40'(yz_s7) + 40'(wx_s7);
			e_s8[8] <= one_c - (40'(xx_s7) + 40'(yy_s7));

			mat.m00 <= aarm_pkg::to_out(e_s8[0]);
			mat.m01 <= aarm_pkg::to_out(e_s8[1]);
			mat.m02 <= aarm_pkg::to_out(e_s8[2]);
			mat.m10 <= aarm_pkg::to_out(e_s8[3]);
			mat.m11 <= aarm_pkg::to_out(e_s8[4]);
			mat.m12 <= aarm_pkg::to_out(e_s8[5]);
			mat.m20 <= aarm_pkg::to_out(e_s8[6]);
			mat.m21 <= aarm_pkg::to_out(e_s8[7]);
			mat.m22 <= aarm_pkg::to_out(e_s8[8]);
		end
	end

endmodule

@@ design/aarm_checker.sv @@
// Checker: port-level assertions for the rotation matrix block, with its bind.
module aarm_assertions (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input aarm_pkg::cmd_t cmd,
	input logic           mat_valid,
	input logic           mat_ready,
	input aarm_pkg::mat_t mat
);

	// Hold a stalled result item unchanged
	a_mat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_ready |=> mat_valid && $stable(mat))
		else $error("result item changed while stalled");

	// Accept input exactly when the output side can move
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready == (!mat_valid || mat_ready))
		else $error("input ready does not follow output stall");

	// A new result appears only after the pipeline advanced
	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mat_valid) |-> $past(cmd_ready))
		else $error("result appeared while pipeline was stalled");

	// Output valid stays unchanged across a stall
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |=> $stable(mat_valid))
		else $error("output valid moved during a stall");

endmodule

bind axis_angle_to_rotation_matrix aarm_assertions u_aarm_checker (.*);
